/* design/ihrl_pkg.sv */
// shared types, codes and constants of the intel hex record loader
`timescale 1ns / 1ps
`default_nettype none

package ihrl_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;

    localparam logic [15:0] RST_BASE_ADDRESS = 16'h8000;
    localparam logic [15:0] RST_FIRST_CHAR_TIMEOUT = 16'd1000;
    localparam logic [15:0] RST_CHAR_TIMEOUT = 16'd10;

    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_FIRST_CHAR_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_CHAR_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] RC_WRITE = 3'd0;
    localparam logic [2:0] RC_DONE = 3'd1;
    localparam logic [2:0] RC_TIMEOUT = 3'd2;
    localparam logic [2:0] RC_BAD_START = 3'd3;
    localparam logic [2:0] RC_CHECKSUM = 3'd4;
    localparam logic [2:0] RC_BAD_DIGIT = 3'd5;
    localparam logic [2:0] RC_TOO_LONG = 3'd6;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [15:0] TICK_MAX = 16'hffff;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_END = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_COLON,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_TRAIL,
        PH_END_CHECK,
        PH_SKIP,
        PH_BURST
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* design/ihrl_buf.sv */
// record byte buffer: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ihrl_buf
    import ihrl_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/intel_hex_record_loader.sv */
// intel hex record loader: record parser, buffer and write burst sequencer
// a single result is registered in the cycle after its request is taken
// a good data record gives its writes one per cycle, after the checksum, while the result
// side does not stall; requests are held off for the whole burst and while a result stalls
// synchronous reset clears the parser and loads register defaults
// buffer content is undefined after reset and gets no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_loader
    import ihrl_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_char_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [2:0]  o_result_code,
    output logic      [15:0] o_write_address,
    output logic      [7:0]  o_write_data,
    output logic             o_last
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic [15:0] r_base, r_first_to, r_char_to;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_nib, n_nib;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_off, n_off;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_idx, n_idx;
    logic [15:0] r_tick, n_tick;

    logic [7:0]  r_rd_k, n_rd_k;
    logic [7:0]  r_em_k, n_em_k;
    logic        r_rd_v, n_rd_v;
    logic [15:0] r_wr_addr, n_wr_addr;

    logic        r_out_valid;
    logic [2:0]  r_out_code;
    logic [15:0] r_out_addr;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    logic        w_in_acc, w_out_acc, w_out_free;
    t_hex        w_hex;
    logic [7:0]  w_byte, w_sum_next;
    logic [15:0] w_tick_inc, w_limit;
    logic        w_timeout, w_burst_ld, w_burst_last, w_rd_en;
    logic [7:0]  w_rdata;

    logic        w_ld;
    logic [2:0]  w_ld_code;
    logic [15:0] w_ld_addr;
    logic [7:0]  w_ld_data;
    logic        w_ld_last;
    logic        w_mem_we;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_phase == PH_BURST) || (r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_hex      = hex_decode(i_char_byte);
    assign w_byte     = {r_high, w_hex.val};
    assign w_sum_next = r_sum + w_byte;
    assign w_tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;
    assign w_limit    = (r_phase == PH_WAIT_COLON || r_phase == PH_SKIP) ? r_first_to
                                                                         : r_char_to;
    assign w_timeout  = w_tick_inc >= w_limit;

    assign w_burst_ld   = (r_phase == PH_BURST) && r_rd_v && w_out_free;
    assign w_burst_last = r_em_k == (r_len - 8'd1);
    assign w_rd_en      = (r_phase == PH_BURST) && (r_rd_k < r_len) && (!r_rd_v || w_burst_ld);

    ihrl_buf #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_byte),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_nib     = r_nib;
        n_high    = r_high;
        n_len     = r_len;
        n_off     = r_off;
        n_type    = r_type;
        n_sum     = r_sum;
        n_idx     = r_idx;
        n_tick    = r_tick;
        n_rd_k    = r_rd_k;
        n_em_k    = r_em_k;
        n_rd_v    = r_rd_v;
        n_wr_addr = r_wr_addr;
        if (r_phase == PH_BURST) begin
            if (w_burst_ld) begin
                n_wr_addr = r_wr_addr + 16'd1;
                n_rd_v    = 1'b0;
                if (w_burst_last) begin
                    n_phase = PH_TRAIL;
                end
            end
            if (w_rd_en) begin
                n_rd_k = r_rd_k + 8'd1;
                n_em_k = r_rd_k;
                n_rd_v = 1'b1;
            end
        end else if (w_in_acc) begin
            unique case (i_kind)
                KIND_START: begin
                    n_phase = PH_WAIT_COLON;
                    n_nib   = 3'd0;
                    n_high  = 4'd0;
                    n_sum   = 8'd0;
                    n_idx   = 8'd0;
                    n_tick  = 16'd0;
                end
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_tick = w_tick_inc;
                        if (w_timeout) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                KIND_CHAR: begin
                    if (r_phase != PH_IDLE) begin
                        n_tick = 16'd0;
                        unique case (r_phase)
                            PH_WAIT_COLON, PH_SKIP: begin
                                if (i_char_byte == CHAR_COLON) begin
                                    n_phase = PH_HEADER;
                                    n_nib   = 3'd0;
                                    n_len   = 8'd0;
                                    n_off   = 16'd0;
                                    n_type  = 8'd0;
                                end else if (r_phase == PH_WAIT_COLON) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_HEADER: begin
                                if (!w_hex.ok) begin
                                    n_phase = PH_IDLE;
                                end else if (!r_nib[0]) begin
                                    n_high = w_hex.val;
                                    n_nib  = r_nib + 3'd1;
                                end else begin
                                    unique case (r_nib[2:1])
                                        2'd0: n_len = w_byte;
                                        2'd1: n_off = {w_byte, 8'd0};
                                        2'd2: n_off = {r_off[15:8], w_byte};
                                        default: n_type = w_byte;
                                    endcase
                                    if (r_nib != 3'd7) begin
                                        n_nib = r_nib + 3'd1;
                                    end else begin
                                        n_nib = 3'd0;
                                        if (w_byte == TYPE_DATA) begin
                                            if ({1'b0, r_len} > DEPTH_W) begin
                                                n_phase = PH_IDLE;
                                            end else begin
                                                n_sum   = r_len + r_off[7:0] + r_off[15:8];
                                                n_idx   = 8'd0;
                                                n_phase = (r_len != 8'd0) ? PH_DATA : PH_CHECK;
                                            end
                                        end else if (w_byte == TYPE_END) begin
                                            n_phase = PH_END_CHECK;
                                        end else begin
                                            n_phase = PH_SKIP;
                                        end
                                    end
                                end
                            end
                            PH_DATA: begin
                                if (!w_hex.ok) begin
                                    n_phase = PH_IDLE;
                                end else if (!r_nib[0]) begin
                                    n_high = w_hex.val;
                                    n_nib  = r_nib + 3'd1;
                                end else begin
                                    n_nib = 3'd0;
                                    n_sum = w_sum_next;
                                    n_idx = r_idx + 8'd1;
                                    if (({1'b0, r_idx} + 9'd1) >= {1'b0, r_len}) begin
                                        n_phase = PH_CHECK;
                                    end
                                end
                            end
                            PH_CHECK: begin
                                if (!w_hex.ok) begin
                                    n_phase = PH_IDLE;
                                end else if (!r_nib[0]) begin
                                    n_high = w_hex.val;
                                    n_nib  = r_nib + 3'd1;
                                end else begin
                                    n_nib = 3'd0;
                                    n_sum = w_sum_next;
                                    if (w_sum_next != 8'd0) begin
                                        n_phase = PH_IDLE;
                                    end else if (r_len != 8'd0) begin
                                        n_phase   = PH_BURST;
                                        n_rd_k    = 8'd0;
                                        n_rd_v    = 1'b0;
                                        n_wr_addr = r_base + r_off;
                                    end else begin
                                        n_phase = PH_TRAIL;
                                    end
                                end
                            end
                            PH_END_CHECK: begin
                                n_nib = r_nib + 3'd1;
                                if ((r_nib + 3'd1) >= 3'd2) begin
                                    n_nib   = 3'd0;
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_TRAIL: n_phase = PH_WAIT_COLON;
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // results and buffer write
    always_comb begin
        w_ld      = 1'b0;
        w_ld_code = RC_WRITE;
        w_ld_addr = 16'd0;
        w_ld_data = 8'd0;
        w_ld_last = 1'b1;
        w_mem_we  = 1'b0;
        if (w_burst_ld) begin
            w_ld      = 1'b1;
            w_ld_addr = r_wr_addr;
            w_ld_data = w_rdata;
            w_ld_last = w_burst_last;
        end else if (w_in_acc && r_phase != PH_IDLE && r_phase != PH_BURST) begin
            if (i_kind == KIND_TICK) begin
                if (w_timeout) begin
                    w_ld      = 1'b1;
                    w_ld_code = RC_TIMEOUT;
                end
            end else if (i_kind == KIND_CHAR) begin
                unique case (r_phase)
                    PH_WAIT_COLON: begin
                        if (i_char_byte != CHAR_COLON) begin
                            w_ld      = 1'b1;
                            w_ld_code = RC_BAD_START;
                        end
                    end
                    PH_HEADER, PH_DATA, PH_CHECK: begin
                        if (!w_hex.ok) begin
                            w_ld      = 1'b1;
                            w_ld_code = RC_BAD_DIGIT;
                        end else if (r_nib[0]) begin
                            if (r_phase == PH_HEADER) begin
                                if (r_nib == 3'd7 && w_byte == TYPE_DATA
                                    && {1'b0, r_len} > DEPTH_W) begin
                                    w_ld      = 1'b1;
                                    w_ld_code = RC_TOO_LONG;
                                end
                            end else if (r_phase == PH_DATA) begin
                                w_mem_we = 1'b1;
                            end else if (w_sum_next != 8'd0) begin
                                w_ld      = 1'b1;
                                w_ld_code = RC_CHECKSUM;
                            end
                        end
                    end
                    PH_END_CHECK: begin
                        if ((r_nib + 3'd1) >= 3'd2) begin
                            w_ld      = 1'b1;
                            w_ld_code = RC_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= RST_BASE_ADDRESS;
            r_first_to  <= RST_FIRST_CHAR_TIMEOUT;
            r_char_to   <= RST_CHAR_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDRESS:       r_base     <= i_cfg_data;
                CFG_FIRST_CHAR_TIMEOUT: r_first_to <= i_cfg_data;
                CFG_CHAR_TIMEOUT:       r_char_to  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_nib       <= 3'd0;
            r_high      <= 4'd0;
            r_len       <= 8'd0;
            r_off       <= 16'd0;
            r_type      <= 8'd0;
            r_sum       <= 8'd0;
            r_idx       <= 8'd0;
            r_tick      <= 16'd0;
            r_rd_k      <= 8'd0;
            r_em_k      <= 8'd0;
            r_rd_v      <= 1'b0;
            r_wr_addr   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_nib     <= n_nib;
            r_high    <= n_high;
            r_len     <= n_len;
            r_off     <= n_off;
            r_type    <= n_type;
            r_sum     <= n_sum;
            r_idx     <= n_idx;
            r_tick    <= n_tick;
            r_rd_k    <= n_rd_k;
            r_em_k    <= n_em_k;
            r_rd_v    <= n_rd_v;
            r_wr_addr <= n_wr_addr;
            if (w_ld) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_out_code <= w_ld_code;
            r_out_addr <= w_ld_addr;
            r_out_data <= w_ld_data;
            r_out_last <= w_ld_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_code   = r_out_code;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_last          = r_out_last;

    a_rd_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> r_phase == PH_BURST)
        else $error("buffer read data held outside a burst");

    a_em_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BURST && r_rd_v) |-> r_em_k < r_len)
        else $error("burst index beyond record length");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_burst_ld && w_burst_last) |=> r_phase == PH_TRAIL)
        else $error("burst did not end after its last write");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld |-> w_out_free)
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire
